FILE: hdl/erfra_pkg.sv
package erfra_pkg;

   localparam int X_W = 20;
   localparam int A_W = 20;
   localparam int H_W = 38;
   localparam int PROD_W = H_W + A_W;
   localparam int V_W = 51;
   localparam int SQ_LO_W = 32;
   localparam int SQ_HI_W = 10;
   localparam int N_W = 50;
   localparam int R_W = 17;
   localparam int Y_W = 18;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int HORNER_STEPS = 6;
   localparam int SQUARE_STEPS = 4;

   localparam logic [H_W-1:0] A1 =
      H_W'((64'd705230784 * 64'd4294967296 + 64'd5000000000) / 64'd10000000000);
   localparam logic [H_W-1:0] A2 =
      H_W'((64'd422820123 * 64'd4294967296 + 64'd5000000000) / 64'd10000000000);
   localparam logic [H_W-1:0] A3 =
      H_W'((64'd92705272 * 64'd4294967296 + 64'd5000000000) / 64'd10000000000);
   localparam logic [H_W-1:0] A4 =
      H_W'((64'd1520143 * 64'd4294967296 + 64'd5000000000) / 64'd10000000000);
   localparam logic [H_W-1:0] A5 =
      H_W'((64'd2765672 * 64'd4294967296 + 64'd5000000000) / 64'd10000000000);
   localparam logic [H_W-1:0] A6 =
      H_W'((64'd430638 * 64'd4294967296 + 64'd5000000000) / 64'd10000000000);
   localparam logic [H_W-1:0] ONE_Q32 = H_W'(64'd4294967296);
   localparam logic [PROD_W-1:0] ROUND16 = PROD_W'(64'd32768);
   localparam logic [V_W-1:0] SQ_LIMIT = V_W'(64'd1 << 41);
   localparam logic [N_W-1:0] ONE_Q48 = N_W'(64'd1 << 48);
   localparam logic [Y_W-1:0] ONE_Q16 = Y_W'(65536);

   typedef struct packed {
      logic valid;
      logic neg;
      logic last;
      logic flush;
   } ctl_type;

   function automatic logic [H_W-1:0] horner_coef(input int unsigned idx);
      logic [H_W-1:0] c;
      case (idx)
         0: c = A5;
         1: c = A4;
         2: c = A3;
         3: c = A2;
         4: c = A1;
         default: c = ONE_Q32;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/erfra_horner.sv
module erfra_horner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  erfra_pkg::ctl_type            ctl_i,
   input  logic [erfra_pkg::A_W-1:0]     a_i,
   input  logic [erfra_pkg::H_W-1:0]     h_i,
   input  logic [erfra_pkg::H_W-1:0]     coef_i,
   output erfra_pkg::ctl_type            ctl_o,
   output logic [erfra_pkg::A_W-1:0]     a_o,
   output logic [erfra_pkg::H_W-1:0]     h_o
);

   erfra_pkg::ctl_type                ctl1_ff, ctl2_ff;
   logic [erfra_pkg::A_W-1:0]         a1_ff, a2_ff;
   logic [erfra_pkg::PROD_W-1:0]      prod_ff, prod_in, prod_rnd;
   logic [erfra_pkg::H_W-1:0]         h_ff, h_in;

   assign prod_in  = erfra_pkg::PROD_W'(h_i) * erfra_pkg::PROD_W'(a_i);
   assign prod_rnd = prod_ff + erfra_pkg::ROUND16;
   assign h_in     = erfra_pkg::H_W'(prod_rnd >> 16) + coef_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (en) begin
         ctl1_ff <= ctl_i;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= a_i;
         prod_ff <= prod_in;
         a2_ff   <= a1_ff;
         h_ff    <= h_in;
      end
   end

   assign ctl_o = ctl2_ff;
   assign a_o   = a2_ff;
   assign h_o   = h_ff;

endmodule

FILE: hdl/erfra_square.sv
module erfra_square (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  erfra_pkg::ctl_type            ctl_i,
   input  logic [erfra_pkg::V_W-1:0]     v_i,
   output erfra_pkg::ctl_type            ctl_o,
   output logic [erfra_pkg::V_W-1:0]     v_o
);

   localparam int HH_W = 2 * erfra_pkg::SQ_HI_W;
   localparam int HL_W = erfra_pkg::SQ_HI_W + erfra_pkg::SQ_LO_W;
   localparam int LL_W = 2 * erfra_pkg::SQ_LO_W;

   erfra_pkg::ctl_type                ctl1_ff, ctl2_ff, ctl1_in;
   logic [erfra_pkg::SQ_HI_W-1:0]     hi;
   logic [erfra_pkg::SQ_LO_W-1:0]     lo;
   logic [HH_W-1:0]                   hh_ff;
   logic [HL_W-1:0]                   hl_ff;
   logic [LL_W-1:0]                   ll_ff;
   logic [LL_W:0]                     ll_rnd;
   logic [erfra_pkg::V_W-1:0]         v_ff, v_in;

   assign hi = v_i[erfra_pkg::SQ_LO_W +: erfra_pkg::SQ_HI_W];
   assign lo = v_i[erfra_pkg::SQ_LO_W-1:0];

   always_comb begin
      ctl1_in = ctl_i;
      ctl1_in.flush = ctl_i.flush | (v_i > erfra_pkg::SQ_LIMIT);
   end

   assign ll_rnd = (LL_W+1)'(ll_ff) + ((LL_W+1)'(1) << (erfra_pkg::SQ_LO_W - 1));
   assign v_in   = (erfra_pkg::V_W'(hh_ff) << erfra_pkg::SQ_LO_W)
                 + (erfra_pkg::V_W'(hl_ff) << 1)
                 + erfra_pkg::V_W'(ll_rnd >> erfra_pkg::SQ_LO_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (en) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= HH_W'(hi) * HH_W'(hi);
         hl_ff <= HL_W'(hi) * HL_W'(lo);
         ll_ff <= LL_W'(lo) * LL_W'(lo);
         v_ff  <= v_in;
      end
   end

   assign ctl_o = ctl2_ff;
   assign v_o   = v_ff;

endmodule

FILE: hdl/erfra_div.sv
module erfra_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  erfra_pkg::ctl_type            ctl_i,
   input  logic [erfra_pkg::V_W-1:0]     q_i,
   input  logic [erfra_pkg::V_W-1:0]     rem_i,
   input  logic [erfra_pkg::R_W-1:0]     low_i,
   input  logic [erfra_pkg::R_W-1:0]     quo_i,
   output erfra_pkg::ctl_type            ctl_o,
   output logic [erfra_pkg::V_W-1:0]     q_o,
   output logic [erfra_pkg::V_W-1:0]     rem_o,
   output logic [erfra_pkg::R_W-1:0]     low_o,
   output logic [erfra_pkg::R_W-1:0]     quo_o
);

   erfra_pkg::ctl_type                ctl_ff;
   logic [erfra_pkg::V_W:0]           trial, diff;
   logic                              ge;
   logic [erfra_pkg::V_W-1:0]         q_ff, rem_ff, rem_in;
   logic [erfra_pkg::R_W-1:0]         low_ff, quo_ff;

   assign trial  = {rem_i, low_i[erfra_pkg::R_W-1]};
   assign diff   = trial - {1'b0, q_i};
   assign ge     = trial >= {1'b0, q_i};
   assign rem_in = ge ? diff[erfra_pkg::V_W-1:0] : trial[erfra_pkg::V_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff   <= q_i;
         rem_ff <= rem_in;
         low_ff <= low_i << 1;
         quo_ff <= {quo_i[erfra_pkg::R_W-2:0], ge};
      end
   end

   assign ctl_o = ctl_ff;
   assign q_o   = q_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;
   assign quo_o = quo_ff;

endmodule

FILE: hdl/erf_rational_approximation_top.sv
// Pipeline from the req transfer to rsp_tvalid (input register, six Horner
// steps of two stages, four squarings of two stages, divider setup, 17 quotient stages,
// output register).
// Throughput: one transfer per cycle; a stalled rsp holds every stage in place.
// Reset: synchronous, active high; clears all valid bits, the pipeline comes up empty.
module erf_rational_approximation_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [erfra_pkg::REQ_DATA_W-1:0]    req_tdata,  // [19:0] x_value
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [erfra_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [17:0] erf_value
   output logic                                rsp_tlast
);

   localparam int NH = erfra_pkg::HORNER_STEPS;
   localparam int NS = erfra_pkg::SQUARE_STEPS;
   localparam int ND = erfra_pkg::R_W;

   logic                              en;
   logic [erfra_pkg::X_W-1:0]         x;
   erfra_pkg::ctl_type                ctl0_ff, ctl0_in;
   logic [erfra_pkg::A_W-1:0]         a0_ff, a0_in;

   erfra_pkg::ctl_type                hctl [0:NH];
   logic [erfra_pkg::A_W-1:0]         ha   [0:NH];
   logic [erfra_pkg::H_W-1:0]         hh   [0:NH];

   erfra_pkg::ctl_type                sctl [0:NS];
   logic [erfra_pkg::V_W-1:0]         sv   [0:NS];

   erfra_pkg::ctl_type                dctl [0:ND];
   logic [erfra_pkg::V_W-1:0]         dq   [0:ND];
   logic [erfra_pkg::V_W-1:0]         drem [0:ND];
   logic [erfra_pkg::R_W-1:0]         dlow [0:ND];
   logic [erfra_pkg::R_W-1:0]         dquo [0:ND];

   erfra_pkg::ctl_type                prep_ctl_ff;
   logic [erfra_pkg::V_W-1:0]         prep_q_ff;
   logic [erfra_pkg::N_W-1:0]         num;
   logic [erfra_pkg::V_W-1:0]         prep_rem_ff;
   logic [erfra_pkg::R_W-1:0]         prep_low_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_last_ff;
   logic [erfra_pkg::Y_W-1:0]         rsp_y_ff, y_pos, y_in;
   logic [erfra_pkg::R_W-1:0]         r_fin;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   assign x = req_tdata[erfra_pkg::X_W-1:0];

   always_comb begin
      ctl0_in.valid = req_tvalid;
      ctl0_in.neg   = x[erfra_pkg::X_W-1];
      ctl0_in.last  = req_tlast;
      ctl0_in.flush = 1'b0;
      a0_in = x[erfra_pkg::X_W-1] ? erfra_pkg::A_W'(-x) : erfra_pkg::A_W'(x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (en) begin
         ctl0_ff <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= a0_in;
      end
   end

   assign hctl[0] = ctl0_ff;
   assign ha[0]   = a0_ff;
   assign hh[0]   = erfra_pkg::A6;

   for (genvar i = 0; i < NH; i++) begin : g_horner
      erfra_horner u_horner (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctl_i  (hctl[i]),
         .a_i    (ha[i]),
         .h_i    (hh[i]),
         .coef_i (erfra_pkg::horner_coef(i)),
         .ctl_o  (hctl[i+1]),
         .a_o    (ha[i+1]),
         .h_o    (hh[i+1])
      );
   end

   assign sctl[0] = hctl[NH];
   assign sv[0]   = erfra_pkg::V_W'(hh[NH]);

   for (genvar i = 0; i < NS; i++) begin : g_square
      erfra_square u_square (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .ctl_i (sctl[i]),
         .v_i   (sv[i]),
         .ctl_o (sctl[i+1]),
         .v_o   (sv[i+1])
      );
   end

   assign num = erfra_pkg::ONE_Q48 + erfra_pkg::N_W'(sv[NS] >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctl_ff <= '0;
      end else if (en) begin
         prep_ctl_ff <= sctl[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_q_ff   <= sv[NS];
         prep_rem_ff <= erfra_pkg::V_W'(num >> erfra_pkg::R_W);
         prep_low_ff <= num[erfra_pkg::R_W-1:0];
      end
   end

   assign dctl[0] = prep_ctl_ff;
   assign dq[0]   = prep_q_ff;
   assign drem[0] = prep_rem_ff;
   assign dlow[0] = prep_low_ff;
   assign dquo[0] = '0;

   for (genvar i = 0; i < ND; i++) begin : g_div
      erfra_div u_div (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .ctl_i (dctl[i]),
         .q_i   (dq[i]),
         .rem_i (drem[i]),
         .low_i (dlow[i]),
         .quo_i (dquo[i]),
         .ctl_o (dctl[i+1]),
         .q_o   (dq[i+1]),
         .rem_o (drem[i+1]),
         .low_o (dlow[i+1]),
         .quo_o (dquo[i+1])
      );
   end

   assign r_fin = dctl[ND].flush ? '0 : dquo[ND];
   assign y_pos = erfra_pkg::ONE_Q16 - erfra_pkg::Y_W'(r_fin);
   assign y_in  = dctl[ND].neg ? -y_pos : y_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dctl[ND].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_y_ff    <= y_in;
         rsp_last_ff <= dctl[ND].last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = erfra_pkg::RSP_DATA_W'(rsp_y_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [erfra_pkg::Y_W-1:0] erf_value;
      logic                      last_out;
   } erf_result_type;

   typedef struct {
      logic [erfra_pkg::X_W-1:0] x_value;
      logic                      last;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [erfra_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // [19:0] x_value
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [erfra_pkg::RSP_DATA_W-1:0] rsp_tdata;  // [17:0] erf_value
   logic rsp_tlast;

   sample_type     pending_samples[$];
   erf_result_type expected_erf[$];
   int             error_count = 0;
   int             idle_cycles = 0;
   int             cycle_count = 0;
   bit             stimulus_done = 1'b0;

   localparam int WATCHDOG_LIMIT = 2000;

   erf_rational_approximation_top DUT (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic erf_result_type predict_erf(sample_type s);
      logic [63:0] coef[5];
      logic [63:0] mag;
      logic [63:0] acc;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] recip;
      logic [63:0] y;
      logic        neg;
      logic        flush;
      erf_result_type res;
      coef[0] = 64'(erfra_pkg::A5);
      coef[1] = 64'(erfra_pkg::A4);
      coef[2] = 64'(erfra_pkg::A3);
      coef[3] = 64'(erfra_pkg::A2);
      coef[4] = 64'(erfra_pkg::A1);
      neg = s.x_value[erfra_pkg::X_W-1];
      mag = neg ? (64'd1 << erfra_pkg::X_W) - 64'(s.x_value) : 64'(s.x_value);
      acc = 64'(erfra_pkg::A6);
      for (int k = 0; k < 5; k++)
         acc = ((acc * mag + 64'h8000) >> 16) + coef[k];
      acc = ((acc * mag + 64'h8000) >> 16) + (64'd1 << 32);
      flush = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (acc > (64'd1 << 41)) begin
            flush = 1'b1;
            break;
         end
         hi = acc >> 32;
         lo = acc & 64'hFFFF_FFFF;
         acc = ((hi * hi) << 32) + 2 * hi * lo + ((lo * lo + 64'h8000_0000) >> 32);
      end
      recip = flush ? 64'd0 : ((64'd1 << 48) + (acc >> 1)) / acc;
      y = 64'd65536 - recip;
      if (neg)
         y = 64'd0 - y;
      res.erf_value = y[erfra_pkg::Y_W-1:0];
      res.last_out = s.last;
      return res;
   endfunction

   task automatic add_sample(logic [erfra_pkg::X_W-1:0] x, logic l);
      sample_type s;
      s.x_value = x;
      s.last = l;
      pending_samples.push_back(s);
   endtask

   initial begin
      logic [erfra_pkg::X_W-1:0] x;
      add_sample(20'h00000, 1'b0);
      add_sample(20'h80000, 1'b1);
      add_sample(20'h7FFFF, 1'b0);
      add_sample(20'h00001, 1'b1);
      add_sample(20'hFFFFF, 1'b0);
      add_sample(20'h10000, 1'b0);
      add_sample(20'hF0000, 1'b1);
      add_sample(20'h08000, 1'b0);
      add_sample(20'hF8000, 1'b0);
      add_sample(20'h20000, 1'b0);
      add_sample(20'h30000, 1'b1);
      add_sample(20'hD0000, 1'b0);
      add_sample(20'h55555, 1'b0);
      add_sample(20'hAAAAA, 1'b1);
      for (int i = 0; i < 750; i++) begin
         case ($urandom_range(0, 3))
            0: x = erfra_pkg::X_W'($urandom);
            1: x = erfra_pkg::X_W'($signed($urandom_range(0, 262143)) - 131072);
            2: x = erfra_pkg::X_W'($signed($urandom_range(0, 32767)) - 16384);
            default: x = erfra_pkg::X_W'($signed($urandom_range(0, 2047)) - 1024);
         endcase
         add_sample(x, 1'($urandom));
      end
   end

   // driver
   always @(posedge clock) begin
      sample_type s;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_samples.size() > 0 &&
             (cycle_count % 2000 < 400 || $urandom_range(0, 99) >= 27)) begin
            s = pending_samples.pop_front();
            expected_erf.push_back(predict_erf(s));
            req_tvalid <= 1'b1;
            req_tdata <= erfra_pkg::REQ_DATA_W'(s.x_value);
            req_tlast <= s.last;
         end else begin
            req_tvalid <= 1'b0;
            if (pending_samples.size() == 0)
               stimulus_done <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      erf_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycle_count % 2000 < 400) || ($urandom_range(0, 99) >= 27);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_erf.size() == 0) begin
               $error("unexpected transfer erf_value %0d",
                      $signed(rsp_tdata[erfra_pkg::Y_W-1:0]));
               error_count++;
            end else begin
               e = expected_erf.pop_front();
               if (rsp_tdata[erfra_pkg::Y_W-1:0] !== e.erf_value) begin
                  $error("erf_value expected %0d actual %0d",
                         $signed(e.erf_value), $signed(rsp_tdata[erfra_pkg::Y_W-1:0]));
                  error_count++;
               end
               if (rsp_tlast !== e.last_out) begin
                  $error("last_out expected %0b actual %0b", e.last_out, rsp_tlast);
                  error_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && !req_tvalid && expected_erf.size() == 0)) begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
      repeat (60) @(posedge clock);
      if (error_count == 0 && !rsp_tvalid)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
